// ----- rtl/pdp_pkg.sv -----
// Shared types, constants and helpers for the pixel delta predictor with escape.
// Used by every module in rtl/; depends on nothing.
package pdp_pkg;

  localparam int unsigned MaxWidthDef = 4096;
  localparam int unsigned QueueDepth  = 4;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_MAX_VALUE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_IMAGE_HEIGHT = 2'd2;

  localparam logic [15:0] MaxValueRst    = 16'hFFFF;
  localparam logic [12:0] ImageWidthRst  = 13'd512;
  localparam logic [15:0] ImageHeightRst = 16'd512;

  // Settings the classifier needs
  typedef struct packed {
    logic [12:0] width;
    logic [15:0] height;
    logic [15:0] thr;
  } pdp_cfg_t;

  // One classified pixel on its way to the emitter
  typedef struct packed {
    logic        lead;     // first pixel of frame: send max value first
    logic        escaped;  // send escape code, then raw pixel
    logic [15:0] value;    // residual symbol or raw pixel
    logic        eof;
  } pdp_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pdp_q_status_t;

  // All ones up to the top set bit; zero counts as one bit deep
  function automatic logic [15:0] escape_code(input logic [15:0] v);
    logic [15:0] s;
    s = v | (v >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    if (s == 16'd0) begin
      s = 16'd1;
    end
    return s;
  endfunction

endpackage

// ----- rtl/pdp_front.sv -----
// Front end: accepts pixels, tracks raster position, holds the previous row
// and classifies each pixel against its predictor. Depends on pdp_pkg.
module pdp_front #(
  parameter int unsigned MAX_WIDTH = pdp_pkg::MaxWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pdp_pkg::pdp_cfg_t cfg_i,
  input  logic              pixel_valid_i,
  output logic              pixel_ready_o,
  input  logic [15:0]       pixel_i,
  output logic              push_o,
  output pdp_pkg::pdp_item_t item_o,
  input  logic              q_full_i
);
  import pdp_pkg::*;

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam logic [ColW-1:0] LastCol = ColW'(MAX_WIDTH - 1);

  logic [15:0] row_mem [MAX_WIDTH];

  logic [ColW-1:0] col_q, col_d;
  logic [15:0]     row_q, row_d;
  logic [15:0]     left_q;
  logic            accept;
  logic            last_col, last_row;

  // Classify stage
  logic        s1_valid_q;
  logic [15:0] s1_px_q, s1_left_q, s1_top_q;
  logic        s1_row0_q, s1_col0_q, s1_eof_q;

  logic [16:0] sum;
  logic [15:0] pred;
  logic [16:0] diff;
  logic [15:0] mag;
  logic        escaped;

  assign pixel_ready_o = !s1_valid_q || !q_full_i;
  assign accept        = pixel_valid_i && pixel_ready_o;
  assign push_o        = s1_valid_q && !q_full_i;

  // A zero width or height makes every column or row the last
  assign last_col = ((17'(col_q) + 17'd1) >= 17'(cfg_i.width)) || (col_q == LastCol);
  assign last_row = (17'(row_q) + 17'd1) >= 17'(cfg_i.height);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? 16'd0 : row_q + 16'd1;
    end else begin
      col_d = col_q + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q      <= col_d;
        row_q      <= row_d;
        left_q     <= pixel_i;
        s1_valid_q <= 1'b1;
      end else if (push_o) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Read the old entry before overwriting it with this pixel
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_top_q        <= row_mem[col_q];
      row_mem[col_q]  <= pixel_i;
      s1_px_q         <= pixel_i;
      s1_left_q       <= left_q;
      s1_row0_q       <= (row_q == 16'd0);
      s1_col0_q       <= (col_q == '0);
      s1_eof_q        <= last_col && last_row;
    end
  end

  always_comb begin
    sum = 17'(s1_left_q) + 17'(s1_top_q);
    if (s1_row0_q) begin
      pred = s1_col0_q ? 16'd0 : s1_left_q;
    end else if (s1_col0_q) begin
      pred = s1_top_q;
    end else begin
      pred = sum[16:1];
    end
    diff    = {1'b0, s1_px_q} - {1'b0, pred};
    mag     = diff[16] ? 16'(-diff) : diff[15:0];
    escaped = (mag >= cfg_i.thr);

    item_o.lead    = s1_row0_q && s1_col0_q;
    item_o.escaped = escaped;
    item_o.value   = escaped ? s1_px_q : (cfg_i.thr + diff[15:0]);
    item_o.eof     = s1_eof_q;
  end

endmodule

// ----- rtl/pdp_fifo.sv -----
// Short queue of classified pixels between front and back end.
// Depends on pdp_pkg.
module pdp_fifo #(
  parameter int unsigned DEPTH = pdp_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pdp_pkg::pdp_item_t    item_i,
  input  logic                  pop_i,
  output pdp_pkg::pdp_item_t    item_o,
  output pdp_pkg::pdp_q_status_t status_o
);
  import pdp_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  pdp_item_t       slots_q [DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign status_o.full  = (cnt_q == CntW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign item_o         = slots_q[rd_q];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= bump(wr_q);
      end
      if (pop_i) begin
        rd_q <= bump(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- rtl/pdp_back.sv -----
// Back end: expands each queued pixel into one to three symbols and holds
// them in the output register. Depends on pdp_pkg.
module pdp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        max_value_i,
  input  logic [15:0]        esc_i,
  input  pdp_pkg::pdp_item_t item_i,
  input  logic               q_empty_i,
  output logic               pop_o,
  output logic               symbol_valid_o,
  input  logic               symbol_ready_i,
  output logic [15:0]        symbol_o,
  output logic               last_of_pixel_o,
  output logic               end_of_frame_o
);
  import pdp_pkg::*;

  logic        lead_done_q, esc_done_q;
  logic        out_valid_q;
  logic [15:0] sym_q;
  logic        last_q, eof_q;
  logic        emit;
  logic        send_lead, send_esc;
  logic [15:0] sym_d;

  assign emit      = !q_empty_i && (!out_valid_q || symbol_ready_i);
  assign send_lead = item_i.lead && !lead_done_q;
  assign send_esc  = !send_lead && item_i.escaped && !esc_done_q;
  assign pop_o     = emit && !send_lead && !send_esc;

  always_comb begin
    if (send_lead) begin
      sym_d = max_value_i;
    end else if (send_esc) begin
      sym_d = esc_i;
    end else begin
      sym_d = item_i.value;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_done_q <= 1'b0;
      esc_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        if (pop_o) begin
          lead_done_q <= 1'b0;
          esc_done_q  <= 1'b0;
        end else if (send_lead) begin
          lead_done_q <= 1'b1;
        end else begin
          esc_done_q  <= 1'b1;
        end
      end else if (symbol_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      sym_q  <= sym_d;
      last_q <= pop_o;
      eof_q  <= pop_o && item_i.eof;
    end
  end

  assign symbol_valid_o  = out_valid_q;
  assign symbol_o        = sym_q;
  assign last_of_pixel_o = last_q;
  assign end_of_frame_o  = eof_q;

endmodule

// ----- rtl/pixel_delta_predictor_escape.sv -----
// Top level of the pixel delta predictor with escape: configuration
// registers, front end, queue and back end. Depends on pdp_pkg and pdp_* modules.
//
//   channel   signals                                     direction
//   pixel     pixel_valid_i / pixel_ready_o / pixel_i     in
//   symbol    symbol_valid_o / symbol_ready_i / symbol_o,  out
//             last_of_pixel_o, end_of_frame_o
//   config    cfg_we_i / cfg_idx_i / cfg_wdata_i          in, write only
//
// A pixel passes the row memory read and classify register, the queue and
// the output register before its first symbol leaves. The single-symbol
// output port sets the rate: one symbol per plain pixel, two per escaped
// pixel, one extra for the leading max value of a frame. Reset clears position
// counters and the queue; the row memory is not cleared. A stalled output
// fills the four-entry queue before the pixel input stalls.
module pixel_delta_predictor_escape #(
  parameter int unsigned MAX_WIDTH = pdp_pkg::MaxWidthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [pdp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [15:0]                  cfg_wdata_i,
  input  logic                         pixel_valid_i,
  output logic                         pixel_ready_o,
  input  logic [15:0]                  pixel_i,
  output logic                         symbol_valid_o,
  input  logic                         symbol_ready_i,
  output logic [15:0]                  symbol_o,
  output logic                         last_of_pixel_o,
  output logic                         end_of_frame_o
);
  import pdp_pkg::*;

  logic [15:0] max_value_q, esc_q;
  logic [12:0] width_q;
  logic [15:0] height_q;

  pdp_cfg_t      cfg;
  pdp_item_t     push_item, head_item;
  pdp_q_status_t q_st;
  logic          push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q <= MaxValueRst;
      esc_q       <= escape_code(MaxValueRst);
      width_q     <= ImageWidthRst;
      height_q    <= ImageHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_VALUE: begin
          max_value_q <= cfg_wdata_i;
          esc_q       <= escape_code(cfg_wdata_i);
        end
        CFG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[12:0];
        CFG_IMAGE_HEIGHT: height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg.width  = width_q;
  assign cfg.height = height_q;
  assign cfg.thr    = esc_q >> 1;

  pdp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i         (cfg),
    .pixel_valid_i,
    .pixel_ready_o,
    .pixel_i,
    .push_o        (push),
    .item_o        (push_item),
    .q_full_i      (q_st.full)
  );

  pdp_fifo #(.DEPTH(QueueDepth)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i   (push),
    .item_i   (push_item),
    .pop_i    (pop),
    .item_o   (head_item),
    .status_o (q_st)
  );

  pdp_back u_back (
    .clk_i,
    .rst_ni,
    .max_value_i     (max_value_q),
    .esc_i           (esc_q),
    .item_i          (head_item),
    .q_empty_i       (q_st.empty),
    .pop_o           (pop),
    .symbol_valid_o,
    .symbol_ready_i,
    .symbol_o,
    .last_of_pixel_o,
    .end_of_frame_o
  );

`ifndef SYNTH
  a_q_not_full_and_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_st.full && q_st.empty))
    else $error("queue reports full and empty together");

  a_pop_needs_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_st.empty)
    else $error("queue popped while empty");

  a_eof_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (symbol_valid_o && end_of_frame_o) |-> last_of_pixel_o)
    else $error("end of frame on a symbol that does not close its pixel");
`endif

endmodule

// ----- tb/sv/pixel_delta_predictor_escape_checker.sv -----
// Checker for the pixel delta predictor with escape: watches the config port and both channels,
// predicts the symbol stream of every accepted pixel and compares it with the block's output.
// Depends on pdp_pkg for the register indexes, reset values and default width.
module pixel_delta_predictor_escape_checker #(
  parameter int unsigned MAX_WIDTH = pdp_pkg::MaxWidthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [pdp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [15:0]                 cfg_wdata_i,
  input  logic                        pixel_valid_i,
  input  logic                        pixel_ready_i,
  input  logic [15:0]                 pixel_i,
  input  logic                        symbol_valid_i,
  input  logic                        symbol_ready_i,
  input  logic [15:0]                 symbol_i,
  input  logic                        last_of_pixel_i,
  input  logic                        end_of_frame_i,
  output int                          mismatches_o,
  output int                          symbols_pending_o
);

  typedef struct packed {
    logic [15:0] symbol;
    logic        last_of_pixel;
    logic        end_of_frame;
  } symbol_rec_t;

  symbol_rec_t expected_symbols[$];
  symbol_rec_t oldest;

  logic [15:0] max_value_q;
  logic [12:0] width_q;
  logic [15:0] height_q;
  logic [15:0] row_mem [MAX_WIDTH];
  logic [15:0] left_q;
  int unsigned col_q;
  int unsigned row_q;

  int mismatch_count = 0;
  int symbols_seen   = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string what);
    $display("[%0t] symbol %0d: %s", $realtime, symbols_seen, what);
    mismatch_count++;
  endtask

  task automatic expect_symbol(input logic [15:0] sym, input logic last, input logic eof);
    symbol_rec_t rec;
    rec.symbol        = sym;
    rec.last_of_pixel = last;
    rec.end_of_frame  = eof;
    expected_symbols.push_back(rec);
  endtask

  // Predict the symbols of one pixel and advance the raster position
  task automatic code_pixel(input logic [15:0] px);
    int unsigned w, h, depth, col, row, pred, esc, thr, mag;
    int          diff, sym;
    logic        last_col, last_row, eof;
    w = width_q;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_q;
    if (h == 0) h = 1;
    col = col_q;
    if (col >= MAX_WIDTH) col = MAX_WIDTH - 1;
    row = row_q;

    depth = 1;
    for (int b = 0; b < 16; b++) begin
      if (max_value_q[b]) depth = b + 1;
    end
    esc = (32'd1 << depth) - 1;
    thr = (32'd1 << (depth - 1)) - 1;

    last_col = (col + 1 >= w);
    last_row = (row + 1 >= h);
    eof      = last_col && last_row;

    if (row == 0) begin
      pred = (col == 0) ? 0 : left_q;
    end else if (col == 0) begin
      pred = row_mem[col];
    end else begin
      pred = (left_q + row_mem[col]) >> 1;
    end

    if (row == 0 && col == 0) expect_symbol(max_value_q, 1'b0, 1'b0);

    diff = int'(px) - int'(pred);
    mag  = (diff < 0) ? -diff : diff;
    if (mag >= thr) begin
      expect_symbol(esc[15:0], 1'b0, 1'b0);
      expect_symbol(px, 1'b1, eof);
    end else begin
      sym = int'(thr) + diff;
      expect_symbol(sym[15:0], 1'b1, eof);
    end

    row_mem[col] = px;
    left_q       = px;
    if (last_col) begin
      col_q = 0;
      row_q = last_row ? 0 : ((row + 1) & 32'hFFFF);
    end else begin
      col_q = col + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_value_q = pdp_pkg::MaxValueRst;
      width_q     = pdp_pkg::ImageWidthRst;
      height_q    = pdp_pkg::ImageHeightRst;
      left_q      = '0;
      col_q       = 0;
      row_q       = 0;
      expected_symbols.delete();
      symbols_pending_o <= 0;
    end else begin
      // Results leave only after their pixel has passed the block's registers, so compare first
      if (symbol_valid_i && symbol_ready_i) begin
        if (expected_symbols.size() == 0) begin
          report_mismatch($sformatf("unexpected symbol %h", symbol_i));
        end else begin
          oldest = expected_symbols.pop_front();
          if (symbol_i !== oldest.symbol)
            report_mismatch($sformatf("symbol %h, want %h", symbol_i, oldest.symbol));
          if (last_of_pixel_i !== oldest.last_of_pixel)
            report_mismatch($sformatf("last_of_pixel %b, want %b",
                                      last_of_pixel_i, oldest.last_of_pixel));
          if (end_of_frame_i !== oldest.end_of_frame)
            report_mismatch($sformatf("end_of_frame %b, want %b",
                                      end_of_frame_i, oldest.end_of_frame));
        end
        symbols_seen++;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          pdp_pkg::CFG_MAX_VALUE:    max_value_q = cfg_wdata_i;
          pdp_pkg::CFG_IMAGE_WIDTH:  width_q     = cfg_wdata_i[12:0];
          pdp_pkg::CFG_IMAGE_HEIGHT: height_q    = cfg_wdata_i;
          default: ;
        endcase
      end

      if (pixel_valid_i && pixel_ready_i) code_pixel(pixel_i);

      symbols_pending_o <= expected_symbols.size();
    end
  end

endmodule

// ----- tb/sv/pixel_delta_predictor_escape_test.sv -----
// Testbench top for the pixel delta predictor with escape: clock, reset, stimulus and verdict.
// Depends on pdp_pkg, the block and pixel_delta_predictor_escape_checker.
module pixel_delta_predictor_escape_test;
  import pdp_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ItemsPerMode = 95;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [15:0]         cfg_wdata_i;
  logic                pixel_valid_i;
  logic                pixel_ready_o;
  logic [15:0]         pixel_i;
  logic                symbol_valid_o;
  logic                symbol_ready_i;
  logic [15:0]         symbol_o;
  logic                last_of_pixel_o;
  logic                end_of_frame_o;

  int          mismatches;
  int          symbols_pending;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned cycles = 0;

  // Current frame settings, for sizing random frames
  int unsigned cur_max;
  int unsigned cur_w;
  int unsigned cur_h;
  logic [15:0] last_px;

  pixel_delta_predictor_escape DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_i        (pixel_i),
    .symbol_valid_o (symbol_valid_o),
    .symbol_ready_i (symbol_ready_i),
    .symbol_o       (symbol_o),
    .last_of_pixel_o(last_of_pixel_o),
    .end_of_frame_o (end_of_frame_o)
  );

  pixel_delta_predictor_escape_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pixel_valid_i    (pixel_valid_i),
    .pixel_ready_i    (pixel_ready_o),
    .pixel_i          (pixel_i),
    .symbol_valid_i   (symbol_valid_o),
    .symbol_ready_i   (symbol_ready_i),
    .symbol_i         (symbol_o),
    .last_of_pixel_i  (last_of_pixel_o),
    .end_of_frame_i   (end_of_frame_o),
    .mismatches_o     (mismatches),
    .symbols_pending_o(symbols_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    symbol_ready_i <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_pixel(input logic [15:0] value);
    if ($urandom_range(99) < send_idle) begin
      pixel_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    pixel_valid_i <= 1'b1;
    pixel_i       <= value;
    last_px        = value;
    do @(posedge clk_i); while (!pixel_ready_o);
  endtask

  // Drop valid and hold until every predicted symbol has left the block
  task automatic wait_idle();
    pixel_valid_i <= 1'b0;
    do @(posedge clk_i); while (symbols_pending != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mix of smooth content, values within range and full-range noise
  function automatic logic [15:0] pick_pixel(input int unsigned maxv, input logic [15:0] prev);
    int unsigned r;
    int          v;
    r = $urandom_range(99);
    if (r < 15) begin
      v = int'($urandom_range(16'hFFFF));
    end else if (r < 50) begin
      v = int'($urandom_range(maxv));
    end else begin
      v = int'(prev) + int'($urandom_range(6)) - 3;
      if (v < 0) v = 0;
      if (v > int'(maxv)) v = int'(maxv);
    end
    return v[15:0];
  endfunction

  task automatic random_frame(inout int unsigned sent);
    int unsigned depth, wv, n;
    if (sent == 0 || $urandom_range(99) < 60) begin
      depth = $urandom_range(16);
      cur_max = (depth == 0) ? 0 : $urandom_range((1 << depth) - 1, 1 << (depth - 1));
      if ($urandom_range(9) == 0) wv = $urandom_range(9, 40);
      else wv = $urandom_range(8);
      cur_w = (wv == 0) ? 1 : wv;
      cur_h = $urandom_range(5);
      wait_idle();
      write_reg(CFG_MAX_VALUE, cur_max[15:0]);
      // bits above the 13-bit width register must be ignored
      write_reg(CFG_IMAGE_WIDTH, {3'($urandom_range(7)), wv[12:0]});
      write_reg(CFG_IMAGE_HEIGHT, cur_h[15:0]);
      if (cur_h == 0) cur_h = 1;
    end
    for (n = 0; n < cur_w * cur_h; n++) begin
      send_pixel(pick_pixel(cur_max, last_px));
    end
    sent += cur_w * cur_h;
  endtask

  initial begin
    int unsigned sent;
    int unsigned mode;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_MAX_VALUE;
    cfg_wdata_i    = '0;
    pixel_valid_i  = 1'b0;
    pixel_i        = '0;
    symbol_ready_i = 1'b0;
    last_px        = '0;
    send_idle      = 34;
    recv_idle      = 71;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: full 16-bit depth, residuals at the escape boundary
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);

    // Oversized width acts as the maximum, height zero as one, then width zero
    // closes the row at once and ends the frame
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 16'h1FFF);
    write_reg(CFG_IMAGE_HEIGHT, 16'd0);
    send_pixel(16'h1234);
    send_pixel(16'h1235);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, 16'd0);
    send_pixel(16'hABCD);

    // Max value zero: one-bit depth, every pixel escaped, every pixel a frame
    wait_idle();
    write_reg(CFG_MAX_VALUE, 16'd0);
    send_pixel(16'h0000);
    send_pixel(16'h0001);

    // Tall frame cut short: shrink height past the current row and width down to the current column
    wait_idle();
    write_reg(CFG_MAX_VALUE, 16'd1);
    write_reg(CFG_IMAGE_WIDTH, 16'd3);
    write_reg(CFG_IMAGE_HEIGHT, 16'hFFFF);
    send_pixel(16'h0001);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    send_pixel(16'h0001);
    send_pixel(16'h0001);
    send_pixel(16'h0000);
    send_pixel(16'hFFFF);
    wait_idle();
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    send_pixel(16'h0000);

    // Pixels above max value
    wait_idle();
    write_reg(CFG_MAX_VALUE, 16'd15);
    write_reg(CFG_IMAGE_WIDTH, 16'd2);
    write_reg(CFG_IMAGE_HEIGHT, 16'd2);
    send_pixel(16'hFFFF);
    send_pixel(16'h0003);
    send_pixel(16'h0010);
    send_pixel(16'h0008);
    cur_max = 15;
    cur_w   = 2;
    cur_h   = 2;

    for (mode = 0; mode < 3; mode++) begin
      if (mode == 1) begin
        send_idle = 71;
        recv_idle = 34;
      end else if (mode == 2) begin
        send_idle = 0;
        recv_idle = 0;
      end
      sent = 0;
      while (sent < ItemsPerMode) random_frame(sent);
    end

    wait_idle();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/pdp_pkg.sv
rtl/pdp_front.sv
rtl/pdp_fifo.sv
rtl/pdp_back.sv
rtl/pixel_delta_predictor_escape.sv
tb/sv/pixel_delta_predictor_escape_checker.sv
tb/sv/pixel_delta_predictor_escape_test.sv
